// File: rtl/core/btod_pkg.sv
// ----------------------------------------------------------------------------
// btod_pkg: shared types, codes and helpers for the BCD time-of-day counter
// Holds the command codes, unit codes, wrap limits and the BCD step functions.
// ----------------------------------------------------------------------------
package btod_pkg;

  typedef enum logic [1:0] {
    MODE_INC   = 2'd0,
    MODE_DEC   = 2'd1,
    MODE_LOAD  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    UNIT_DECI = 2'd0,
    UNIT_SEC  = 2'd1,
    UNIT_MIN  = 2'd2,
    UNIT_HOUR = 2'd3
  } unit_t;

  localparam int NUM_UNITS = 4;

  localparam logic [7:0] WRAP_DECI   = 8'd9;
  localparam logic [7:0] WRAP_MINSEC = 8'h59;
  localparam logic [7:0] WRAP_HOUR   = 8'h23;

  typedef logic [NUM_UNITS-1:0][7:0] units_t;

  typedef struct packed {
    units_t                 units;
    logic                   day_wrapped;
    logic [NUM_UNITS-1:0]   changed;
  } result_t;

  function automatic logic [7:0] bcd_up(input logic [7:0] x);
    logic [7:0] y;
    y = x + 8'd1;
    if (y[3:0] == 4'hA) begin
      y = y + 8'd6;
    end
    return y;
  endfunction

  function automatic logic [7:0] bcd_down(input logic [7:0] x);
    logic [7:0] y;
    y = x - 8'd1;
    if (y[3:0] == 4'hF) begin
      y = y - 8'd6;
    end
    return y;
  endfunction

  function automatic logic [7:0] unit_top(input unit_t u);
    logic [7:0] top;
    unique case (u)
      UNIT_DECI: top = WRAP_DECI;
      UNIT_HOUR: top = WRAP_HOUR;
      default:   top = WRAP_MINSEC;
    endcase
    return top;
  endfunction

endpackage

// File: rtl/core/btod_next.sv
// ----------------------------------------------------------------------------
// btod_next: next-state logic of the BCD time-of-day counter
// Works out the counter state and the result fields that one item produces.
// ----------------------------------------------------------------------------
module btod_next (
  input  btod_pkg::mode_t   mode,
  input  btod_pkg::unit_t   unit,
  input  logic              cascade,
  input  logic [7:0]        load_value,
  input  btod_pkg::units_t  cur,
  output btod_pkg::result_t res
);

  logic [btod_pkg::NUM_UNITS-1:0] wrap;
  logic [btod_pkg::NUM_UNITS-1:0] active;
  btod_pkg::units_t               stepped;

  always_comb begin
    for (int i = 0; i < btod_pkg::NUM_UNITS; i++) begin
      if (mode == btod_pkg::MODE_INC) begin
        wrap[i] = (cur[i] == btod_pkg::unit_top(btod_pkg::unit_t'(i)));
        if (wrap[i]) begin
          stepped[i] = 8'd0;
        end else if (i == 0) begin
          stepped[i] = cur[i] + 8'd1;
        end else begin
          stepped[i] = btod_pkg::bcd_up(cur[i]);
        end
      end else begin
        wrap[i] = (cur[i] == 8'd0);
        if (wrap[i]) begin
          stepped[i] = btod_pkg::unit_top(btod_pkg::unit_t'(i));
        end else if (i == 0) begin
          stepped[i] = cur[i] - 8'd1;
        end else begin
          stepped[i] = btod_pkg::bcd_down(cur[i]);
        end
      end
    end

    active[0] = (unit == btod_pkg::UNIT_DECI);
    for (int i = 1; i < btod_pkg::NUM_UNITS; i++) begin
      active[i] = (unit == btod_pkg::unit_t'(i)) ||
                  (cascade && active[i-1] && wrap[i-1]);
    end

    res.units       = cur;
    res.day_wrapped = 1'b0;
    res.changed     = '0;
    unique case (mode)
      btod_pkg::MODE_CLEAR: begin
        res.units   = '0;
        res.changed = '1;
      end
      btod_pkg::MODE_LOAD: begin
        res.units[unit]   = load_value;
        res.changed[unit] = 1'b1;
      end
      default: begin
        for (int i = 0; i < btod_pkg::NUM_UNITS; i++) begin
          if (active[i]) begin
            res.units[i] = stepped[i];
          end
        end
        res.changed     = active;
        res.day_wrapped = active[btod_pkg::NUM_UNITS-1] && wrap[btod_pkg::NUM_UNITS-1];
      end
    endcase
  end

endmodule

// File: rtl/core/bcd_time_of_day_counter.sv
// ----------------------------------------------------------------------------
// bcd_time_of_day_counter: BCD time-of-day counter with edit commands
// Each item increments, decrements, loads or clears the time of day and
// returns one result holding the full time after the item.
// ----------------------------------------------------------------------------
// The input channel carries a command (mode, unit, cascade, load_value);
// the result channel carries deciseconds, seconds, minutes and hours after
// that command, the day-wrap flag and the mask of rewritten units.
// Every accepted item yields exactly one result, which is valid in the
// cycle after acceptance. The time registers are updated at the clock
// edge that accepts the item, so the next item may enter in the very next
// cycle: one item per cycle while the receiver keeps taking results.
// The result register is the only buffering stage. While it holds a result
// that the receiver has not taken, in_ready follows out_ready, so a stalled
// receiver holds off new items without losing any.
// Synchronous reset clears the time to 00:00:00.0 and empties the result
// register.
// ----------------------------------------------------------------------------
module bcd_time_of_day_counter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [1:0] in_unit,
  input  logic       in_cascade,
  input  logic [7:0] in_load_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_deciseconds,
  output logic [7:0] out_seconds_bcd,
  output logic [7:0] out_minutes_bcd,
  output logic [7:0] out_hours_bcd,
  output logic       out_day_wrapped,
  output logic [3:0] out_changed_units
);

  btod_pkg::units_t  time_r;
  btod_pkg::result_t res_r;
  btod_pkg::result_t res_nxt;
  logic              out_valid_r;
  logic              accept;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  btod_next u_next (
    .mode       (btod_pkg::mode_t'(in_mode)),
    .unit       (btod_pkg::unit_t'(in_unit)),
    .cascade    (in_cascade),
    .load_value (in_load_value),
    .cur        (time_r),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        time_r      <= res_nxt.units;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_deciseconds   = res_r.units[btod_pkg::UNIT_DECI];
  assign out_seconds_bcd   = res_r.units[btod_pkg::UNIT_SEC];
  assign out_minutes_bcd   = res_r.units[btod_pkg::UNIT_MIN];
  assign out_hours_bcd     = res_r.units[btod_pkg::UNIT_HOUR];
  assign out_day_wrapped   = res_r.day_wrapped;
  assign out_changed_units = res_r.changed;

endmodule

// File: rtl/core/btod_checker.sv
// ----------------------------------------------------------------------------
// btod_checker: port-level checks for the BCD time-of-day counter
// Watches the top level's channels and the consistency of its result fields.
// ----------------------------------------------------------------------------
module btod_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_mode,
  input logic [1:0] in_unit,
  input logic       in_cascade,
  input logic [7:0] in_load_value,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_deciseconds,
  input logic [7:0] out_seconds_bcd,
  input logic [7:0] out_minutes_bcd,
  input logic [7:0] out_hours_bcd,
  input logic       out_day_wrapped,
  input logic [3:0] out_changed_units
);

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("An accepted item did not produce a result in the next cycle.");

  a_changed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_changed_units != 4'd0)
    else $error("A result reports no rewritten unit.");

  a_wrap_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_day_wrapped |->
      out_changed_units[3] && (out_hours_bcd == 8'h00 || out_hours_bcd == 8'h23))
    else $error("A day wrap is reported without a matching hours value.");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_deciseconds) &&
      $stable(out_seconds_bcd) && $stable(out_minutes_bcd) &&
      $stable(out_hours_bcd) && $stable(out_day_wrapped) &&
      $stable(out_changed_units))
    else $error("A stalled result was dropped or changed.");

  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_mode) && $stable(in_unit) &&
      $stable(in_cascade) && $stable(in_load_value))
    else $error("A waiting input item was withdrawn or changed.");

endmodule

bind bcd_time_of_day_counter btod_checker u_btod_checker (.*);

// File: test/bcd_time_of_day_counter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcd_time_of_day_counter_tb: self-checking bench for the BCD time-of-day counter
// A driver feeds edit items from a queue and a monitor predicts the time after
// each accepted item and compares every result field. Directed items cover
// wraps, cascades, clears and invalid BCD, then random items run under four
// flow-control settings.
// ----------------------------------------------------------------------------
module bcd_time_of_day_counter_tb;

  typedef struct {
    btod_pkg::mode_t mode;
    btod_pkg::unit_t unit;
    logic            cascade;
    logic [7:0]      load;
  } edit_t;

  typedef struct {
    logic [7:0] deci;
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hour;
    logic       wrapped;
    logic [3:0] changed;
  } tod_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_mode = 2'd0;
  logic [1:0] in_unit = 2'd0;
  logic       in_cascade = 1'b0;
  logic [7:0] in_load_value = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_deciseconds;
  logic [7:0] out_seconds_bcd;
  logic [7:0] out_minutes_bcd;
  logic [7:0] out_hours_bcd;
  logic       out_day_wrapped;
  logic [3:0] out_changed_units;

  edit_t      pending_edits[$];
  tod_t       expected_times[$];
  logic [7:0] tod_units[btod_pkg::NUM_UNITS];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         edits_issued = 0;
  int         results_checked = 0;
  int         day_wraps = 0;
  int         errors = 0;
  logic       in_taken = 1'b0;
  edit_t      next_edit;
  edit_t      seen_edit;
  tod_t       want;

  bcd_time_of_day_counter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_unit          (in_unit),
    .in_cascade       (in_cascade),
    .in_load_value    (in_load_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_deciseconds  (out_deciseconds),
    .out_seconds_bcd  (out_seconds_bcd),
    .out_minutes_bcd  (out_minutes_bcd),
    .out_hours_bcd    (out_hours_bcd),
    .out_day_wrapped  (out_day_wrapped),
    .out_changed_units(out_changed_units)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] rollover_limit(input int u);
    if (u == int'(btod_pkg::UNIT_DECI)) begin
      return btod_pkg::WRAP_DECI;
    end else if (u == int'(btod_pkg::UNIT_HOUR)) begin
      return btod_pkg::WRAP_HOUR;
    end
    return btod_pkg::WRAP_MINSEC;
  endfunction

  function automatic logic [7:0] nibble_inc(input logic [7:0] x);
    logic [7:0] y;
    y = x + 8'd1;
    if (y[3:0] == 4'hA) begin
      y = y + 8'd6;
    end
    return y;
  endfunction

  function automatic logic [7:0] nibble_dec(input logic [7:0] x);
    logic [7:0] y;
    y = x - 8'd1;
    if (y[3:0] == 4'hF) begin
      y = y - 8'd6;
    end
    return y;
  endfunction

  // Applies one edit to the predicted time and returns the expected result.
  function automatic tod_t apply_edit(input edit_t e);
    tod_t r;
    int   u;
    logic at_limit;
    logic rippling;
    r.wrapped = 1'b0;
    r.changed = '0;
    case (e.mode)
      btod_pkg::MODE_CLEAR: begin
        foreach (tod_units[i]) begin
          tod_units[i] = 8'd0;
        end
        r.changed = '1;
      end
      btod_pkg::MODE_LOAD: begin
        tod_units[e.unit] = e.load;
        r.changed[e.unit] = 1'b1;
      end
      default: begin
        u = int'(e.unit);
        rippling = 1'b1;
        while (rippling) begin
          if (e.mode == btod_pkg::MODE_INC) begin
            at_limit = (tod_units[u] == rollover_limit(u));
            if (at_limit) begin
              tod_units[u] = 8'd0;
            end else if (u == int'(btod_pkg::UNIT_DECI)) begin
              tod_units[u] = tod_units[u] + 8'd1;
            end else begin
              tod_units[u] = nibble_inc(tod_units[u]);
            end
          end else begin
            at_limit = (tod_units[u] == 8'd0);
            if (at_limit) begin
              tod_units[u] = rollover_limit(u);
            end else if (u == int'(btod_pkg::UNIT_DECI)) begin
              tod_units[u] = tod_units[u] - 8'd1;
            end else begin
              tod_units[u] = nibble_dec(tod_units[u]);
            end
          end
          r.changed[u] = 1'b1;
          if (at_limit && u == int'(btod_pkg::UNIT_HOUR)) begin
            r.wrapped = 1'b1;
          end
          rippling = at_limit && e.cascade && u < int'(btod_pkg::UNIT_HOUR);
          u++;
        end
      end
    endcase
    r.deci = tod_units[btod_pkg::UNIT_DECI];
    r.sec  = tod_units[btod_pkg::UNIT_SEC];
    r.min  = tod_units[btod_pkg::UNIT_MIN];
    r.hour = tod_units[btod_pkg::UNIT_HOUR];
    return r;
  endfunction

  function automatic edit_t make_edit(input btod_pkg::mode_t m, input btod_pkg::unit_t u,
                                      input logic c, input logic [7:0] v);
    edit_t e;
    e.mode = m;
    e.unit = u;
    e.cascade = c;
    e.load = v;
    return e;
  endfunction

  function automatic void queue_edit(input edit_t e);
    pending_edits.push_back(e);
    edits_issued++;
  endfunction

  // Mostly ticks and well-formed loads that sit near the wrap points, with
  // some raw bytes and the odd clear.
  function automatic edit_t random_edit();
    edit_t e;
    int    pick;
    int    top;
    int    v;
    e.unit = btod_pkg::unit_t'($urandom_range(3));
    e.cascade = ($urandom_range(99) < 70);
    e.load = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 60) begin
      e.mode = ($urandom_range(1) != 0) ? btod_pkg::MODE_DEC : btod_pkg::MODE_INC;
    end else if (pick < 85) begin
      e.mode = btod_pkg::MODE_LOAD;
      top = (e.unit == btod_pkg::UNIT_DECI) ? 9 : (e.unit == btod_pkg::UNIT_HOUR) ? 23 : 59;
      case ($urandom_range(3))
        0: v = 0;
        1: v = top;
        default: v = $urandom_range(top);
      endcase
      e.load = (e.unit == btod_pkg::UNIT_DECI) ? 8'(v) : {4'(v / 10), 4'(v % 10)};
    end else if (pick < 96) begin
      e.mode = btod_pkg::MODE_LOAD;
    end else begin
      e.mode = btod_pkg::MODE_CLEAR;
    end
    return e;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_val,
                                      input logic [7:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, exp_val, got_val);
      errors++;
    end
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    while (results_checked != edits_issued) begin
      @(negedge clk);
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    int i;
    @(posedge clk);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (i = 0; i < count; i++) begin
      queue_edit(random_edit());
    end
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (pending_edits.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_edit = pending_edits.pop_front();
          in_valid <= 1'b1;
          in_mode <= next_edit.mode;
          in_unit <= next_edit.unit;
          in_cascade <= next_edit.cascade;
          in_load_value <= next_edit.load;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
      foreach (tod_units[i]) begin
        tod_units[i] = 8'd0;
      end
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        seen_edit = make_edit(btod_pkg::mode_t'(in_mode), btod_pkg::unit_t'(in_unit),
                              in_cascade, in_load_value);
        expected_times.push_back(apply_edit(seen_edit));
      end
      if (out_valid && out_ready) begin
        if (expected_times.size() == 0) begin
          $error("Result arrived with no item outstanding");
          errors++;
        end else begin
          want = expected_times.pop_front();
          check_field("deciseconds", want.deci, out_deciseconds);
          check_field("seconds_bcd", want.sec, out_seconds_bcd);
          check_field("minutes_bcd", want.min, out_minutes_bcd);
          check_field("hours_bcd", want.hour, out_hours_bcd);
          check_field("day_wrapped", 8'(want.wrapped), 8'(out_day_wrapped));
          check_field("changed_units", 8'(want.changed), 8'(out_changed_units));
          if (want.wrapped) begin
            day_wraps++;
          end
          results_checked++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Full-depth borrow and carry, bare hour wraps, then invalid BCD stepping by
    // the nibble rule and out-of-range deciseconds stepping in plain binary.
    @(posedge clk);
    queue_edit(make_edit(btod_pkg::MODE_CLEAR, btod_pkg::UNIT_DECI, 1'b0, 8'h00));
    queue_edit(make_edit(btod_pkg::MODE_DEC, btod_pkg::UNIT_DECI, 1'b1, 8'hFF));
    queue_edit(make_edit(btod_pkg::MODE_INC, btod_pkg::UNIT_DECI, 1'b1, 8'h00));
    queue_edit(make_edit(btod_pkg::MODE_DEC, btod_pkg::UNIT_HOUR, 1'b0, 8'h00));
    queue_edit(make_edit(btod_pkg::MODE_INC, btod_pkg::UNIT_HOUR, 1'b1, 8'h00));
    queue_edit(make_edit(btod_pkg::MODE_LOAD, btod_pkg::UNIT_SEC, 1'b0, 8'h59));
    queue_edit(make_edit(btod_pkg::MODE_INC, btod_pkg::UNIT_SEC, 1'b0, 8'h00));
    queue_edit(make_edit(btod_pkg::MODE_LOAD, btod_pkg::UNIT_DECI, 1'b1, 8'hFF));
    queue_edit(make_edit(btod_pkg::MODE_INC, btod_pkg::UNIT_DECI, 1'b1, 8'hFF));
    queue_edit(make_edit(btod_pkg::MODE_LOAD, btod_pkg::UNIT_DECI, 1'b0, 8'h80));
    queue_edit(make_edit(btod_pkg::MODE_DEC, btod_pkg::UNIT_DECI, 1'b1, 8'h00));
    queue_edit(make_edit(btod_pkg::MODE_LOAD, btod_pkg::UNIT_MIN, 1'b0, 8'h99));
    queue_edit(make_edit(btod_pkg::MODE_INC, btod_pkg::UNIT_MIN, 1'b1, 8'h00));
    queue_edit(make_edit(btod_pkg::MODE_LOAD, btod_pkg::UNIT_MIN, 1'b0, 8'h10));
    queue_edit(make_edit(btod_pkg::MODE_DEC, btod_pkg::UNIT_MIN, 1'b1, 8'hFF));
    queue_edit(make_edit(btod_pkg::MODE_LOAD, btod_pkg::UNIT_SEC, 1'b1, 8'hFF));
    queue_edit(make_edit(btod_pkg::MODE_INC, btod_pkg::UNIT_SEC, 1'b1, 8'h00));
    queue_edit(make_edit(btod_pkg::MODE_LOAD, btod_pkg::UNIT_HOUR, 1'b0, 8'hAA));
    queue_edit(make_edit(btod_pkg::MODE_DEC, btod_pkg::UNIT_HOUR, 1'b1, 8'h55));
    queue_edit(make_edit(btod_pkg::MODE_LOAD, btod_pkg::UNIT_HOUR, 1'b0, 8'h23));
    queue_edit(make_edit(btod_pkg::MODE_INC, btod_pkg::UNIT_MIN, 1'b1, 8'h00));
    queue_edit(make_edit(btod_pkg::MODE_CLEAR, btod_pkg::UNIT_HOUR, 1'b1, 8'hFF));
    wait_drained();

    run_phase(0, 0, 110);
    run_phase(49, 0, 110);
    run_phase(0, 49, 110);
    run_phase(38, 38, 110);

    repeat (4) @(posedge clk);
    if (expected_times.size() != 0) begin
      $error("%0d results never arrived", expected_times.size());
      errors++;
    end
    $display("Checked %0d results from directed and random edits under four flow-control",
             results_checked);
    $display("settings; %0d of them wrapped the day.", day_wraps);
    if (errors == 0) begin
      $display("[bcd_time_of_day_counter] OK");
    end else begin
      $display("[bcd_time_of_day_counter] ERROR");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("[bcd_time_of_day_counter] ERROR");
    $finish;
  end

endmodule
